// ----- sv/lph_pkg.sv -----
// ----------------------------------------------------------------------------
// lph_pkg
// shared sizes and item codes for the liang pattern hyphenator
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int MaxWord     = 64;
  localparam int MaxPattern  = 16;
  localparam int TableSlots  = 4096;

  localparam int WordAw      = $clog2(MaxWord);
  localparam int GapDepth    = MaxWord + 1;
  localparam int GapAw       = $clog2(GapDepth);
  localparam int PosW        = $clog2(MaxPattern + 1);
  localparam int PatAw       = $clog2(MaxPattern);
  localparam int SlotAw      = $clog2(TableSlots);
  localparam int CountW      = $clog2(TableSlots + 1);
  localparam int SymDepth    = TableSlots * MaxPattern;
  localparam int SymAw       = $clog2(SymDepth);
  localparam int DigDepth    = TableSlots * (MaxPattern + 1);
  localparam int DigAw       = $clog2(DigDepth);
  localparam int LenW        = $clog2(MaxWord + 1);

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_WORD  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

endpackage

// ----- sv/lph_ram.sv -----
// ----------------------------------------------------------------------------
// lph_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/liang_pattern_hyphenator.sv -----
// ----------------------------------------------------------------------------
// liang_pattern_hyphenator
// liang pattern hyphenation against a loadable pattern table
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  kind symbol digit_before digit_after last
// out      output     out_valid / out_stall mask gap_count overflow
//
// a stored final pattern symbol makes a second write to the digit memory, for
//   the trailing digit, in S_LOAD2
// a final word character starts scoring: the gap scores are cleared, then for
//   each start position each stored pattern has its length looked up, its
//   symbols compared and, on a match, its digits applied; then the search is
//   left, each gap is read into the mask and the result is posted
// all work goes through one sequencer and single-port memory reads
// rst is synchronous; it empties the table and drops any partial word
// a finished result waits in the output register; new transactions are
//   taken meanwhile, but the next result waits until the old one is taken
module liang_pattern_hyphenator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] symbol,
  input  logic [3:0]  digit_before,
  input  logic [3:0]  digit_after,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [62:0] mask,
  output logic [5:0]  gap_count,
  output logic        overflow
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD2, S_CLR, S_JCHK, S_SLOT, S_LEN, S_CMP_RD, S_CMP,
    S_APP_RD, S_APP_WR, S_MSK_RD, S_MSK, S_DONE
  } state_t;

  state_t state;

  // table bookkeeping
  logic [lph_pkg::CountW-1:0] count;
  logic [lph_pkg::PosW-1:0]   pos;
  logic                       too_long;
  logic [lph_pkg::DigAw-1:0]  ld_addr;
  logic [3:0]                 ld_dig;

  // word collection
  logic [lph_pkg::LenW-1:0]   wlen;
  logic                       wovf;
  logic [lph_pkg::LenW-1:0]   len;
  logic                       ovf_hold;

  // scoring loop counters
  logic [lph_pkg::WordAw-1:0] j;
  logic [lph_pkg::CountW-1:0] s;
  logic [lph_pkg::PosW-1:0]   i;
  logic [lph_pkg::PosW-1:0]   n;
  logic [lph_pkg::GapAw-1:0]  g;
  logic [62:0]                mask_acc;

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // slot base addresses: 16 symbols and 17 digits per slot
  logic [lph_pkg::SlotAw-1:0] ld_slot;
  logic [lph_pkg::DigAw-1:0]  ld_base;
  logic [lph_pkg::DigAw-1:0]  sc_base;
  logic                       room;
  logic                       pos_ok;
  assign ld_slot = count[lph_pkg::SlotAw-1:0];
  assign ld_base = lph_pkg::DigAw'({ld_slot, {lph_pkg::PatAw{1'b0}}})
                 + lph_pkg::DigAw'(ld_slot);
  assign sc_base = lph_pkg::DigAw'({s[lph_pkg::SlotAw-1:0], {lph_pkg::PatAw{1'b0}}})
                 + lph_pkg::DigAw'(s[lph_pkg::SlotAw-1:0]);
  assign room    = (count < lph_pkg::CountW'(lph_pkg::TableSlots));
  assign pos_ok  = (pos < lph_pkg::PosW'(lph_pkg::MaxPattern));

  // memory ports
  logic                        sym_we;
  logic [lph_pkg::SymAw-1:0]   sym_waddr, sym_raddr;
  logic [15:0]                 sym_rdata;
  logic                        dig_we;
  logic [lph_pkg::DigAw-1:0]   dig_waddr, dig_raddr;
  logic [3:0]                  dig_wdata, dig_rdata;
  logic                        plen_we;
  logic [lph_pkg::PosW-1:0]    plen_rdata;
  logic                        wch_we;
  logic [15:0]                 wch_rdata;
  logic [lph_pkg::WordAw-1:0]  wch_raddr;
  logic                        gap_we;
  logic [lph_pkg::GapAw-1:0]   gap_waddr, gap_raddr, ji;
  logic [3:0]                  gap_wdata, gap_rdata;

  logic is_load, is_word, fin_ok;
  assign is_load = accept && (kind == lph_pkg::KIND_LOAD);
  assign is_word = accept && (kind == lph_pkg::KIND_WORD);
  // pattern is committed when it fits and the table has room
  assign fin_ok  = is_load && last && !too_long && pos_ok && room;

  assign ji        = lph_pkg::GapAw'(j) + lph_pkg::GapAw'(i);
  assign wch_raddr = ji[lph_pkg::WordAw-1:0];
  assign sym_waddr = {ld_slot, pos[lph_pkg::PatAw-1:0]};
  assign sym_raddr = {s[lph_pkg::SlotAw-1:0], i[lph_pkg::PatAw-1:0]};
  assign sym_we    = is_load && pos_ok && room;
  assign dig_raddr = sc_base + lph_pkg::DigAw'(i);

  always_comb begin
    dig_we    = 1'b0;
    dig_waddr = ld_base + lph_pkg::DigAw'(pos);
    dig_wdata = digit_before;
    if (state == S_LOAD2) begin
      dig_we    = 1'b1;
      dig_waddr = ld_addr;
      dig_wdata = ld_dig;
    end else if (sym_we) begin
      dig_we = 1'b1;
    end
  end

  assign plen_we = fin_ok;
  assign wch_we  = is_word && (wlen < lph_pkg::LenW'(lph_pkg::MaxWord));

  always_comb begin
    gap_we    = 1'b0;
    gap_waddr = g;
    gap_wdata = '0;
    gap_raddr = (state == S_APP_RD) ? ji : g;
    if (state == S_CLR) begin
      gap_we = 1'b1;
    end else if (state == S_APP_WR) begin
      gap_we    = 1'b1;
      gap_waddr = ji;
      gap_wdata = (gap_rdata < dig_rdata) ? dig_rdata : gap_rdata;
    end
  end

  lph_ram #(.WIDTH(16), .DEPTH(lph_pkg::SymDepth)) u_sym (
    .clk, .we(sym_we), .waddr(sym_waddr), .wdata(symbol),
    .raddr(sym_raddr), .rdata(sym_rdata)
  );

  lph_ram #(.WIDTH(4), .DEPTH(lph_pkg::DigDepth)) u_dig (
    .clk, .we(dig_we), .waddr(dig_waddr), .wdata(dig_wdata),
    .raddr(dig_raddr), .rdata(dig_rdata)
  );

  lph_ram #(.WIDTH(lph_pkg::PosW), .DEPTH(lph_pkg::TableSlots)) u_plen (
    .clk, .we(plen_we), .waddr(ld_slot), .wdata(pos + 1'b1),
    .raddr(s[lph_pkg::SlotAw-1:0]), .rdata(plen_rdata)
  );

  lph_ram #(.WIDTH(16), .DEPTH(lph_pkg::MaxWord)) u_wch (
    .clk, .we(wch_we), .waddr(wlen[lph_pkg::WordAw-1:0]), .wdata(symbol),
    .raddr(wch_raddr), .rdata(wch_rdata)
  );

  lph_ram #(.WIDTH(4), .DEPTH(lph_pkg::GapDepth)) u_gap (
    .clk, .we(gap_we), .waddr(gap_waddr), .wdata(gap_wdata),
    .raddr(gap_raddr), .rdata(gap_rdata)
  );

  // characters left from start j to the word end
  logic [lph_pkg::LenW-1:0] rem;
  assign rem = len - lph_pkg::LenW'(j);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pos       <= '0;
      too_long  <= 1'b0;
      wlen      <= '0;
      wovf      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (kind)
              lph_pkg::KIND_LOAD: begin
                if (pos_ok) begin
                  if (last) begin
                    // trailing digit goes in a second write
                    ld_addr <= ld_base + lph_pkg::DigAw'(pos) + 1'b1;
                    ld_dig  <= digit_after;
                    if (room) begin
                      state <= S_LOAD2;
                    end
                  end else begin
                    pos <= pos + 1'b1;
                  end
                end else begin
                  too_long <= 1'b1;
                end
                if (last) begin
                  if (fin_ok) begin
                    count <= count + 1'b1;
                  end
                  pos      <= '0;
                  too_long <= 1'b0;
                end
              end
              lph_pkg::KIND_WORD: begin
                if (wch_we) begin
                  wlen <= wlen + 1'b1;
                end else begin
                  wovf <= 1'b1;
                end
                if (last) begin
                  len      <= wch_we ? wlen + 1'b1 : wlen;
                  ovf_hold <= wovf || !wch_we;
                  wlen     <= '0;
                  wovf     <= 1'b0;
                  g        <= '0;
                  state    <= S_CLR;
                end
              end
              lph_pkg::KIND_CLEAR: begin
                count    <= '0;
                pos      <= '0;
                too_long <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_LOAD2: state <= S_IDLE;
        S_CLR: begin
          // zero gap scores 0..len
          if (g == lph_pkg::GapAw'(len)) begin
            j     <= '0;
            state <= S_JCHK;
          end else begin
            g <= g + 1'b1;
          end
        end
        S_JCHK: begin
          if (lph_pkg::LenW'(j) + lph_pkg::LenW'(2) < len) begin
            s     <= '0;
            state <= S_SLOT;
          end else begin
            mask_acc <= '0;
            g        <= lph_pkg::GapAw'(1);
            state    <= (len > lph_pkg::LenW'(1)) ? S_MSK_RD : S_DONE;
          end
        end
        S_SLOT: begin
          if (s < count) begin
            state <= S_LEN;
          end else begin
            j     <= j + 1'b1;
            state <= S_JCHK;
          end
        end
        S_LEN: begin
          n <= plen_rdata;
          if (plen_rdata == '0 ||
              plen_rdata > lph_pkg::PosW'(lph_pkg::MaxPattern) ||
              lph_pkg::LenW'(plen_rdata) > rem) begin
            s     <= s + 1'b1;
            state <= S_SLOT;
          end else begin
            i     <= '0;
            state <= S_CMP_RD;
          end
        end
        S_CMP_RD: state <= S_CMP;
        S_CMP: begin
          if (sym_rdata != wch_rdata) begin
            s     <= s + 1'b1;
            state <= S_SLOT;
          end else if (i + 1'b1 == n) begin
            i     <= '0;
            state <= S_APP_RD;
          end else begin
            i     <= i + 1'b1;
            state <= S_CMP_RD;
          end
        end
        S_APP_RD: state <= S_APP_WR;
        S_APP_WR: begin
          // digits 0..n raise the scores by maximum
          if (i == n) begin
            s     <= s + 1'b1;
            state <= S_SLOT;
          end else begin
            i     <= i + 1'b1;
            state <= S_APP_RD;
          end
        end
        S_MSK_RD: state <= S_MSK;
        S_MSK: begin
          if (gap_rdata[0]) begin
            mask_acc[6'(g - 1'b1)] <= 1'b1;
          end
          if (lph_pkg::LenW'(g) + lph_pkg::LenW'(1) < len) begin
            g     <= g + 1'b1;
            state <= S_MSK_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            mask      <= (len > lph_pkg::LenW'(1)) ? mask_acc : '0;
            gap_count <= 6'(len - 1'b1);
            overflow  <= ovf_hold;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (i < n))
    else $error("symbol index past pattern length");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LEN) |-> (s < count))
    else $error("slot lookup beyond table count");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !(out_valid && out_stall)) |=> out_valid)
    else $error("finished word did not reach output");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR || state == S_CMP) |-> in_stall)
    else $error("input taken while scoring");
`endif

endmodule

// ----- tb/sv/liang_pattern_hyphenator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// liang_pattern_hyphenator_tb
// checks the hyphenator against a built-in liang pattern predictor: patterns
// are loaded and cleared, words are scored, and every mask, gap count and
// overflow flag is compared with the predicted one, under random idling on
// both channels and a long output hold-off
// ----------------------------------------------------------------------------
module liang_pattern_hyphenator_tb;

  localparam logic [1:0] KindNoise = 2'd3;  // unused code, block ignores it
  localparam int NumItems = 1900;
  localparam int LongHold = 2500;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] sym;
    logic [3:0]  dbefore;
    logic [3:0]  dafter;
    logic        fin;
  } hy_item_t;

  typedef struct {
    logic [62:0] mask;
    logic [5:0]  gaps;
    logic        ovf;
  } hy_word_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [15:0] symbol;
  logic [3:0]  digit_before;
  logic [3:0]  digit_after;
  logic        last;
  logic        out_valid;
  logic        out_stall;
  logic [62:0] mask;
  logic [5:0]  gap_count;
  logic        overflow;

  int  mismatches = 0;
  int  items_sent = 0;
  bit  tx_no_gap  = 0;   // sender burst mode, no idle cycles
  bit  hold_go    = 0;   // asks the hold process for one long output stall
  logic hold_req;

  liang_pattern_hyphenator i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .symbol       (symbol),
    .digit_before (digit_before),
    .digit_after  (digit_after),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mask         (mask),
    .gap_count    (gap_count),
    .overflow     (overflow)
  );

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // hyphenation scoreboard: pattern table, word buffer and pending masks
  // --------------------------------------------------------------------------
  class hyphen_scoreboard;
    logic [15:0] pat_sym [lph_pkg::TableSlots][lph_pkg::MaxPattern];
    logic [3:0]  pat_dig [lph_pkg::TableSlots][lph_pkg::MaxPattern+1];
    int          pat_len [lph_pkg::TableSlots];
    int          pat_count, load_pos;
    bit          load_long;
    logic [15:0] word [lph_pkg::MaxWord];
    int          word_len;
    bit          word_ovf;
    hy_word_t    pending[$];

    function new();
      pat_count = 0; load_pos = 0; load_long = 0; word_len = 0; word_ovf = 0;
    endfunction

    function void load_symbol(hy_item_t it);
      if (load_pos < lph_pkg::MaxPattern) begin
        if (pat_count < lph_pkg::TableSlots) begin
          pat_sym[pat_count][load_pos] = it.sym;
          pat_dig[pat_count][load_pos] = it.dbefore;
        end
        load_pos++;
        if (it.fin && pat_count < lph_pkg::TableSlots)
          pat_dig[pat_count][load_pos] = it.dafter;
      end else begin
        load_long = 1;
      end
      if (it.fin) begin
        if (!load_long && pat_count < lph_pkg::TableSlots) begin
          pat_len[pat_count] = load_pos;
          pat_count++;
        end
        load_pos = 0;
        load_long = 0;
      end
    endfunction

    // score every start position below len-2 against every stored pattern
    function hy_word_t hyphenate();
      logic [3:0] score [lph_pkg::MaxWord+1];
      hy_word_t   r;
      int         n;
      bit         same;
      foreach (score[g]) score[g] = '0;
      for (int j = 0; j + 2 < word_len; j++) begin
        for (int s = 0; s < pat_count; s++) begin
          n = pat_len[s];
          if (n == 0 || n > word_len - j) continue;
          same = 1;
          for (int i = 0; i < n; i++)
            if (pat_sym[s][i] != word[j+i]) same = 0;
          if (!same) continue;
          for (int i = 0; i <= n; i++)
            if (score[j+i] < pat_dig[s][i]) score[j+i] = pat_dig[s][i];
        end
      end
      r.mask = '0;
      for (int i = 0; i + 1 < word_len && i < 63; i++) r.mask[i] = score[i+1][0];
      r.gaps = 6'(word_len - 1);
      r.ovf  = word_ovf;
      return r;
    endfunction

    function void note_input(hy_item_t it);
      case (it.kind)
        lph_pkg::KIND_LOAD:  load_symbol(it);
        lph_pkg::KIND_CLEAR: begin
          pat_count = 0; load_pos = 0; load_long = 0;
        end
        lph_pkg::KIND_WORD: begin
          if (word_len < lph_pkg::MaxWord) begin
            word[word_len] = it.sym;
            word_len++;
          end else begin
            word_ovf = 1;
          end
          if (it.fin) begin
            pending.push_back(hyphenate());
            word_len = 0;
            word_ovf = 0;
          end
        end
        default: ;
      endcase
    endfunction

    task check_result(logic [62:0] m, logic [5:0] g, logic o);
      hy_word_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, mask %h", m));
        return;
      end
      e = pending.pop_front();
      if (m !== e.mask)
        report_mismatch($sformatf("mask %h, predicted %h", m, e.mask));
      if (g !== e.gaps)
        report_mismatch($sformatf("gap_count %0d, predicted %0d", g, e.gaps));
      if (o !== e.ovf)
        report_mismatch($sformatf("overflow %0b, predicted %0b", o, e.ovf));
    endtask
  endclass

  hyphen_scoreboard sb = new();

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // one long output hold-off, timed in its own process
  initial begin
    hold_req = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_req <= 1'b1;
    repeat (LongHold) @(posedge clk);
    hold_req <= 1'b0;
  end

  // result side: random stall per transaction, checks each accepted result
  initial begin
    int  rx_wait;
    bit  rx_fast;
    rx_wait = 0;
    rx_fast = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_result(mask, gap_count, overflow);
        if ($urandom_range(0, 7) == 0) rx_fast = ~rx_fast;
        rx_wait = rx_fast ? 0 : $urandom_range(0, 8);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= hold_req || (rx_wait > 0);
    end
  end

  // --------------------------------------------------------------------------
  // sender tasks
  // --------------------------------------------------------------------------
  // offer one transaction after a random gap, return once it is taken
  task automatic send(input logic [1:0] k, input logic [15:0] s,
                      input logic [3:0] db, input logic [3:0] da, input logic f);
    hy_item_t it;
    int       gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.kind = k; it.sym = s; it.dbefore = db; it.dafter = da; it.fin = f;
    in_valid     <= 1'b1;
    kind         <= k;
    symbol       <= s;
    digit_before <= db;
    digit_after  <= da;
    last         <= f;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
  endtask

  // wait for every pending mask, then let the sequencer settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // small alphabet so patterns actually match words; sometimes any symbol
  function automatic logic [15:0] pick_sym();
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return 16'h0061 + 16'($urandom_range(0, 3));
  endfunction

  function automatic logic [3:0] pick_digit();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(10, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  task automatic send_pattern(input int n);
    for (int i = 0; i < n; i++)
      send(lph_pkg::KIND_LOAD, pick_sym(), pick_digit(), pick_digit(), i == n - 1);
  endtask

  task automatic send_word(input int n);
    for (int i = 0; i < n; i++)
      send(lph_pkg::KIND_WORD, pick_sym(), 4'($urandom()), 4'($urandom()),
           i == n - 1);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int sel;
    int n;
    in_valid = 1'b0;
    kind = lph_pkg::KIND_LOAD;
    symbol = '0;
    digit_before = '0;
    digit_after = '0;
    last = 1'b0;
    @(negedge rst);
    @(posedge clk);

    // directed: empty table, one-character word, field extremes
    send(lph_pkg::KIND_WORD, 16'hFFFF, 4'hF, 4'hF, 1'b1);
    send(lph_pkg::KIND_WORD, 16'h0000, 4'h0, 4'h0, 1'b0);
    send(lph_pkg::KIND_WORD, 16'hFFFF, 4'h0, 4'h0, 1'b1);
    // pattern "1 ffff 3 0000 15" and a duplicate of it
    repeat (2) begin
      send(lph_pkg::KIND_LOAD, 16'hFFFF, 4'd1, 4'd0, 1'b0);
      send(lph_pkg::KIND_LOAD, 16'h0000, 4'd3, 4'd15, 1'b1);
    end
    // digits above nine and single symbol pattern
    send(lph_pkg::KIND_LOAD, 16'h0000, 4'd9, 4'd11, 1'b1);
    send(lph_pkg::KIND_WORD, 16'h0000, 4'd0, 4'd0, 1'b0);
    send(lph_pkg::KIND_WORD, 16'hFFFF, 4'd0, 4'd0, 1'b0);
    send(lph_pkg::KIND_WORD, 16'h0000, 4'd0, 4'd0, 1'b0);
    send(lph_pkg::KIND_WORD, 16'h0000, 4'd0, 4'd0, 1'b1);
    // ignored kind and a pattern too long to keep
    send(KindNoise, 16'h5A5A, 4'd7, 4'd7, 1'b1);
    for (int i = 0; i <= lph_pkg::MaxPattern; i++)
      send(lph_pkg::KIND_LOAD, 16'h0000, 4'd1, 4'd1, i == lph_pkg::MaxPattern);
    // clear in the middle of a pattern, the word in progress survives
    send(lph_pkg::KIND_WORD, 16'hFFFF, 4'd0, 4'd0, 1'b0);
    send(lph_pkg::KIND_LOAD, 16'h0000, 4'd1, 4'd1, 1'b0);
    send(lph_pkg::KIND_CLEAR, 16'hFFFF, 4'hF, 4'hF, 1'b1);
    send(lph_pkg::KIND_WORD, 16'h0000, 4'd0, 4'd0, 1'b1);
    // word beyond the length bound
    send_pattern(2);
    send_word(lph_pkg::MaxWord + 3);
    drain();
    send(lph_pkg::KIND_CLEAR, 16'h0, 4'd0, 4'd0, 1'b0);

    // random: mostly well-formed patterns and words, some noise
    hold_go = 1;
    while (items_sent < NumItems) begin
      if ($urandom_range(0, 5) == 0) tx_no_gap = ~tx_no_gap;
      if (sb.pat_count > 40)
        send(lph_pkg::KIND_CLEAR, 16'($urandom()), 4'($urandom()),
             4'($urandom()), 1'($urandom()));
      sel = $urandom_range(0, 99);
      if (sel < 32) begin
        n = $urandom_range(0, 9) == 0 ? $urandom_range(5, lph_pkg::MaxPattern + 4)
                                      : $urandom_range(1, 4);
        send_pattern(n);
      end else if (sel < 90) begin
        n = $urandom_range(0, 29) == 0
              ? $urandom_range(lph_pkg::MaxWord - 4, lph_pkg::MaxWord + 6)
              : $urandom_range(1, 12);
        send_word(n);
      end else if (sel < 94) begin
        send(lph_pkg::KIND_CLEAR, 16'($urandom()), 4'($urandom()), 4'($urandom()),
             1'($urandom()));
      end else if (sel < 97) begin
        send(KindNoise, 16'($urandom()), 4'($urandom()), 4'($urandom()),
             1'($urandom()));
      end else begin
        // abandoned pattern followed by a clear
        send_pattern(0);
        send(lph_pkg::KIND_LOAD, pick_sym(), pick_digit(), pick_digit(), 1'b0);
        send(lph_pkg::KIND_CLEAR, 16'h0, 4'd0, 4'd0, 1'b0);
      end
      if ($urandom_range(0, 199) == 0) drain();
    end

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
sv/lph_pkg.sv
sv/lph_ram.sv
sv/liang_pattern_hyphenator.sv
tb/sv/liang_pattern_hyphenator_tb.sv
